// File: rtl/swma_pkg.sv
// ----------------------------------------------------------------------------
// swma_pkg
// Types and constants shared by the stack with middle access and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package swma_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam logic signed [DATA_W-1:0] MIDDLE_EMPTY = '1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_DELMID = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] middle;
      logic                      middle_valid;
      logic [CNT_W-1:0]          count;
      status_type                status;
   } rsp_type;

   typedef enum logic {
      CTL_IDLE   = 1'b0,
      CTL_MIDDLE = 1'b1
   } ctl_state_type;

   typedef struct packed {
      logic exec;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/swma_ctrl.sv
// ----------------------------------------------------------------------------
// swma_ctrl
// Sequencer: takes one transaction, then loads the result once the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  swma_pkg::dp_status_type dp_status,
   output swma_pkg::ctl_cmd_type   cmd
);
   import swma_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd.exec     = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = CTL_MIDDLE;
            end
         end
         CTL_MIDDLE: begin
            if (!dp_status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/swma_datapath.sv
// ----------------------------------------------------------------------------
// swma_datapath
// Entry registers, fill count, middle read-out and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  swma_pkg::req_type       req_payload,
   input  swma_pkg::ctl_cmd_type   cmd,
   output swma_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output swma_pkg::rsp_type       rsp_payload
);
   import swma_pkg::*;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   status_type               status_ff;
   status_type               status_in;
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [CNT_W-1:0]         half;
   logic [IDX_W-1:0]         mid_idx;
   logic                     empty;
   logic                     full;

   assign half    = count_ff >> 1;
   assign mid_idx = half[IDX_W-1:0];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      if (cmd.exec) begin
         status_in = ST_OK;
         unique case (req_payload.op)
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_OVER;
               end else begin
                  entries_in[count_ff[IDX_W-1:0]] = req_payload.value;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               if (empty) begin
                  status_in = ST_UNDER;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_DELMID: begin
               if (empty) begin
                  status_in = ST_UNDER;
               end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     if ((CNT_W'(i) >= half) && (CNT_W'(i + 1) < count_ff)) begin
                        entries_in[i] = entries_ff[i + 1];
                     end
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_QUERY: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.middle       = empty ? MIDDLE_EMPTY : entries_ff[mid_idx];
      rsp_in.middle_valid = !empty;
      rsp_in.count        = count_ff;
      rsp_in.status       = status_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      status_ff  <= status_in;
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign dp_status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && req_payload.op == OP_PUSH && !full)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the stack");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending transaction overwritten");

   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.middle_valid == (rsp_ff.count != '0)))
      else $error("middle valid flag disagrees with count");

endmodule

`default_nettype wire

// File: rtl/stack_with_middle_access.sv
// ----------------------------------------------------------------------------
// stack_with_middle_access
// Bounded stack of signed words with read-out and removal of the middle entry.
//
// Usage: the request channel (req_valid, req_stall, req_payload) carries one
// operation per transaction: push, pop, delete middle or query. Each request
// gives exactly one transaction on the result channel (rsp_valid, rsp_stall,
// rsp_payload) with the middle entry after the operation, its valid flag,
// the fill count and a status code.
// A request is handled in order: the edge that accepts it updates the entry
// registers and count, and a later edge, once the output register is free,
// reads the middle entry into the output register. A new request is taken
// only after the result of the last one has been loaded into that register.
// The output register keeps its transaction while the receiver stalls; a
// further request is still taken, and its result waits until the register
// frees up. Reset empties the stack at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_middle_access (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  swma_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output swma_pkg::rsp_type  rsp_payload
);
   import swma_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   swma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   swma_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// File: tb/sv/stack_checker.sv
// ----------------------------------------------------------------------------
// stack_checker
// Watches both channels of the stack with middle access. It keeps its own
// copy of the stack, works out the middle report for every accepted request
// and compares each accepted result with the oldest report still due.
// ----------------------------------------------------------------------------
module stack_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  swma_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  swma_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import swma_pkg::*;

   logic signed [DATA_W-1:0] stack_words [DEPTH];
   int                       stack_fill;
   rsp_type                  reports_due [$];

   initial begin
      fail_count = 0;
      pending = 0;
      stack_fill = 0;
   end

   function automatic rsp_type apply_stack_op(input req_type r);
      rsp_type res;
      int      i;
      res.status = ST_OK;
      case (r.op)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               res.status = ST_OVER;
            end else begin
               stack_words[stack_fill] = r.value;
               stack_fill++;
            end
         end
         OP_POP: begin
            if (stack_fill == 0) res.status = ST_UNDER;
            else stack_fill--;
         end
         OP_DELMID: begin
            if (stack_fill == 0) begin
               res.status = ST_UNDER;
            end else begin
               for (i = stack_fill / 2; i + 1 < stack_fill; i++)
                  stack_words[i] = stack_words[i + 1];
               stack_fill--;
            end
         end
         default: ;
      endcase
      if (stack_fill == 0) begin
         res.middle = MIDDLE_EMPTY;
         res.middle_valid = 1'b0;
      end else begin
         res.middle = stack_words[stack_fill / 2];
         res.middle_valid = 1'b1;
      end
      res.count = CNT_W'(stack_fill);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stack_fill = 0;
         reports_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_payload.middle !== want.middle) begin
                  $error("middle: expected %0d, actual %0d", want.middle, rsp_payload.middle);
                  fail_count++;
               end
               if (rsp_payload.middle_valid !== want.middle_valid) begin
                  $error("middle_valid: expected %0b, actual %0b",
                         want.middle_valid, rsp_payload.middle_valid);
                  fail_count++;
               end
               if (rsp_payload.count !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_payload.count);
                  fail_count++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            reports_due.push_back(apply_stack_op(req_payload));
      end
      pending <= reports_due.size();
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the stack with middle access with a directed run through the empty
// and full corners followed by random operations in alternating fill and
// drain phases, with random idling and stalling on both channels. The
// checker beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import swma_pkg::*;

   localparam int RANDOM_OPS = 750;
   localparam logic signed [DATA_W-1:0] CORNER_WORDS [7] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    calm;
   int      fail_count;
   int      pending;

   always #5 clock = ~clock;

   stack_with_middle_access dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   stack_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      if (reset || calm) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 28);
   end

   task automatic send_op(input op_type kind, input logic signed [DATA_W-1:0] word);
      if (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_payload <= req_type'{kind, word};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic op_type pick_op(input bit filling);
      int r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 65) return OP_PUSH;
         if (r < 77) return OP_POP;
         if (r < 89) return OP_DELMID;
         return OP_QUERY;
      end
      if (r < 25) return OP_PUSH;
      if (r < 55) return OP_POP;
      if (r < 85) return OP_DELMID;
      return OP_QUERY;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_word();
      if ($urandom_range(7) == 0) return CORNER_WORDS[$urandom_range(6)];
      return $urandom;
   endfunction

   initial begin
      bit filling;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      calm <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty stack corners
      send_op(OP_QUERY, 32'h1234_5678);
      send_op(OP_POP, '0);
      send_op(OP_DELMID, '0);
      // fill to the top, extremes first
      for (int i = 0; i < DEPTH; i++)
         send_op(OP_PUSH, (i < 7) ? CORNER_WORDS[i] : $urandom);
      send_op(OP_PUSH, 32'h0BAD_F00D);
      send_op(OP_QUERY, '0);
      send_op(OP_DELMID, '0);
      send_op(OP_POP, '0);
      send_op(OP_DELMID, '0);

      filling = 1'b0;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 40 == 0) filling = ~filling;
         if (n == 300) calm <= 1'b1;
         if (n == 450) calm <= 1'b0;
         if (n == 550) wait_drained();
         send_op(pick_op(filling), pick_word());
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS stack_with_middle_access");
      end else begin
         $display("FAIL stack_with_middle_access");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL stack_with_middle_access");
      $finish;
   end

endmodule

// File: files.f
rtl/swma_pkg.sv
rtl/swma_ctrl.sv
rtl/swma_datapath.sv
rtl/stack_with_middle_access.sv
tb/sv/stack_checker.sv
tb/sv/testbench.sv
